FILE: sv/rapm_pkg.sv
`timescale 1ns / 1ps

package rapm_pkg;

   // Field widths
   localparam int POS_W = 13;   // range bounds and array length
   localparam int AMT_W = 30;   // add amount
   localparam int SUM_W = 64;   // store entries and running sums
   localparam int MAX_W = 63;   // reported maximum
   localparam int CNT_W = 16;   // ignored-query count

   localparam logic [POS_W-1:0] LEN_RESET = 13'd4096;
   localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

   // Controller to datapath
   typedef struct packed {
      logic query_load;   // latch the query beat, issue read of start entry
      logic upd_a;        // write start entry, issue read of end entry
      logic upd_b;        // write end entry
      logic sweep_start;  // begin a read-and-zero pass over the store
      logic scan_acc;     // accumulate running sum and maximum during the pass
      logic result_load;  // load output registers, clear the tally
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic query_final;  // latched query ends the job
      logic sweep_done;   // last store entry handled this cycle
   } dp_stat_type;

endpackage

FILE: sv/rapm_ifs.sv
`timescale 1ns / 1ps

interface rapm_req_if;
   logic                           valid;
   logic                           ready;
   logic [rapm_pkg::POS_W-1:0]     range_start;
   logic [rapm_pkg::POS_W-1:0]     range_end;
   logic [rapm_pkg::AMT_W-1:0]     add_amount;
   logic                           final_query;

   modport source (output valid, range_start, range_end, add_amount, final_query,
                   input ready);
   modport sink   (input valid, range_start, range_end, add_amount, final_query,
                   output ready);
endinterface

interface rapm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rapm_pkg::MAX_W-1:0]     max_value;
   logic [rapm_pkg::CNT_W-1:0]     ignored_count;

   modport source (output valid, max_value, ignored_count, input ready);
   modport sink   (input valid, max_value, ignored_count, output ready);
endinterface

FILE: sv/range_add_max_prefix_core.sv
`timescale 1ns / 1ps

// Range-add / max-prefix engine built on a difference store.
// req_chan: one query beat (range_start, range_end, add_amount, final_query).
//   Bounds are one-based and inclusive. A query with start 0, end beyond the
//   length, or start after end is dropped and counted (count saturates).
// rsp_chan: one result beat per job (max_value, ignored_count), sent after
//   the query marked final_query has been applied.
// csr_wr_en/csr_wr_data: array length; 0 acts as 1, above MAX_LENGTH acts as
//   MAX_LENGTH. Write only between queries.
// Per query: accept, then one read-modify-write of the start entry and one of the
//   end entry on the store's one write port; no query is taken meanwhile.
// Final query: both store updates, then a pass that reads and zeroes every
//   store entry and sums those within the length, then a step that loads
//   the output register and raises rsp_chan.valid.
// Reset: a clearing pass zeroes all MAX_LENGTH+1 entries; req_chan.ready stays
//   low until the pass is done. Length resets to 4096.
// rsp stall: the result sits in an output register, so queries of the next
//   job are taken meanwhile; the next final scan runs, then holds with
//   req_chan.ready low until the register drains.

module range_add_max_prefix_core #(
   parameter int MAX_LENGTH = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   rapm_req_if.sink                     req_chan,
   rapm_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [rapm_pkg::POS_W-1:0]   csr_wr_data
);

   rapm_pkg::dp_cmd_type  cmd;
   rapm_pkg::dp_stat_type stat;

   // sequencing: clear pass, query updates, scan, result hand-off
   rapm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, running sum/max, tally, length register and output payload
   rapm_dp #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .q_start       (req_chan.range_start),
      .q_end         (req_chan.range_end),
      .q_amount      (req_chan.add_amount),
      .q_final       (req_chan.final_query),
      .cmd           (cmd),
      .stat          (stat),
      .max_value     (rsp_chan.max_value),
      .ignored_count (rsp_chan.ignored_count)
   );

endmodule

FILE: sv/rapm_ctrl.sv
`timescale 1ns / 1ps

module rapm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rapm_pkg::dp_stat_type stat,
   output rapm_pkg::dp_cmd_type  cmd
);

   localparam logic [2:0] S_CLR_GO   = 3'd0;
   localparam logic [2:0] S_CLR_WAIT = 3'd1;
   localparam logic [2:0] S_IDLE     = 3'd2;
   localparam logic [2:0] S_UPD_A    = 3'd3;
   localparam logic [2:0] S_UPD_B    = 3'd4;
   localparam logic [2:0] S_SCAN     = 3'd5;
   localparam logic [2:0] S_RESULT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLR_GO: begin
            cmd.sweep_start = 1'b1;
            state_in        = S_CLR_WAIT;
         end
         S_CLR_WAIT: begin
            if (stat.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.query_load = 1'b1;
               state_in       = S_UPD_A;
            end
         end
         S_UPD_A: begin
            cmd.upd_a = 1'b1;
            state_in  = S_UPD_B;
         end
         S_UPD_B: begin
            cmd.upd_b = 1'b1;
            if (stat.query_final) begin
               cmd.sweep_start = 1'b1;
               state_in        = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_acc = 1'b1;
            if (stat.sweep_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR_GO;
         end
      endcase
   end

   always_comb begin
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR_GO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/rapm_dp.sv
`timescale 1ns / 1ps

module rapm_dp #(
   parameter int MAX_LENGTH = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [rapm_pkg::POS_W-1:0]   csr_wr_data,
   input  logic [rapm_pkg::POS_W-1:0]   q_start,
   input  logic [rapm_pkg::POS_W-1:0]   q_end,
   input  logic [rapm_pkg::AMT_W-1:0]   q_amount,
   input  logic                         q_final,
   input  rapm_pkg::dp_cmd_type         cmd,
   output rapm_pkg::dp_stat_type        stat,
   output logic [rapm_pkg::MAX_W-1:0]   max_value,
   output logic [rapm_pkg::CNT_W-1:0]   ignored_count
);

   localparam int DEPTH = MAX_LENGTH + 1;
   localparam int AW    = $clog2(MAX_LENGTH + 1);
   localparam int CW    = (AW > rapm_pkg::POS_W) ? AW : rapm_pkg::POS_W;
   localparam logic [CW-1:0] MAX_LEN_C = CW'(MAX_LENGTH);
   localparam logic [AW-1:0] LAST_IDX  = AW'(MAX_LENGTH);

   // length register and the clamped value in effect
   logic [rapm_pkg::POS_W-1:0] len_ff, len_in;
   logic [CW-1:0]              len_x, eff_len;

   // query check
   logic [CW-1:0] start_x, end_x;
   logic          q_ok;

   // latched query
   logic [AW-1:0]              qa_ff, qa_in, qb_ff, qb_in;
   logic [rapm_pkg::AMT_W-1:0] amt_ff, amt_in;
   logic                       ok_ff, ok_in, final_ff, final_in;
   logic [rapm_pkg::CNT_W-1:0] tally_ff, tally_in;

   // difference store
   logic [rapm_pkg::SUM_W-1:0] mem [DEPTH];
   logic [rapm_pkg::SUM_W-1:0] rdata_ff, wr_data;
   logic [AW-1:0]              rd_addr, wr_addr;
   logic                       wr_en;
   logic [rapm_pkg::SUM_W-1:0] amt_ext;

   // sweep
   logic          run_ff, run_in, sv_ff, sv_in;
   logic [AW-1:0] idx_ff, idx_in, sidx_ff, sidx_in;

   // scan arithmetic
   logic [rapm_pkg::SUM_W-1:0] sum_ff, sum_in, best_ff, best_in, sum_nx;
   logic                       first, in_len, acc;

   logic [rapm_pkg::MAX_W-1:0] out_max_ff, out_max_in;
   logic [rapm_pkg::CNT_W-1:0] out_cnt_ff, out_cnt_in;

   always_comb begin
      len_x = CW'(len_ff);
      if (len_x == '0) begin
         eff_len = CW'(1);
      end else if (len_x > MAX_LEN_C) begin
         eff_len = MAX_LEN_C;
      end else begin
         eff_len = len_x;
      end
   end

   assign len_in  = csr_wr_en ? csr_wr_data : len_ff;

   assign start_x = CW'(q_start);
   assign end_x   = CW'(q_end);
   assign q_ok    = (start_x != '0) && (end_x <= eff_len) && (start_x <= end_x);

   assign qa_in    = cmd.query_load ? AW'(start_x - CW'(1)) : qa_ff;
   assign qb_in    = cmd.query_load ? AW'(end_x) : qb_ff;
   assign amt_in   = cmd.query_load ? q_amount : amt_ff;
   assign ok_in    = cmd.query_load ? q_ok : ok_ff;
   assign final_in = cmd.query_load ? q_final : final_ff;

   always_comb begin
      tally_in = tally_ff;
      if (cmd.result_load) begin
         tally_in = '0;
      end else if (cmd.query_load && !q_ok && (tally_ff != rapm_pkg::CNT_MAX)) begin
         tally_in = tally_ff + 1'b1;
      end
   end

   // store ports: one write, one registered read per cycle
   assign amt_ext = rapm_pkg::SUM_W'(amt_ff);

   always_comb begin
      if (run_ff) begin
         rd_addr = idx_ff;
      end else if (cmd.upd_a) begin
         rd_addr = qb_ff;
      end else begin
         rd_addr = qa_in;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = qa_ff;
      wr_data = rdata_ff + amt_ext;
      if (sv_ff) begin
         wr_en   = 1'b1;
         wr_addr = sidx_ff;
         wr_data = '0;
      end else if (cmd.upd_a) begin
         wr_en = ok_ff;
      end else if (cmd.upd_b) begin
         wr_en   = ok_ff;
         wr_addr = qb_ff;
         wr_data = rdata_ff - amt_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // sweep reads every entry once and zeroes it in the following cycle
   always_comb begin
      run_in = run_ff;
      idx_in = idx_ff;
      if (cmd.sweep_start) begin
         run_in = 1'b1;
         idx_in = '0;
      end else if (run_ff) begin
         if (idx_ff == LAST_IDX) begin
            run_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   assign sv_in   = run_ff;
   assign sidx_in = idx_ff;

   assign first  = (sidx_ff == '0);
   assign sum_nx = first ? rdata_ff : (sum_ff + rdata_ff);
   assign in_len = (CW'(sidx_ff) < eff_len);
   assign acc    = cmd.scan_acc && sv_ff && in_len;

   assign sum_in  = acc ? sum_nx : sum_ff;
   assign best_in = (acc && (first || (sum_nx > best_ff))) ? sum_nx : best_ff;

   assign out_max_in = cmd.result_load ? best_ff[rapm_pkg::MAX_W-1:0] : out_max_ff;
   assign out_cnt_in = cmd.result_load ? tally_ff : out_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= rapm_pkg::LEN_RESET;
         tally_ff <= '0;
         run_ff   <= 1'b0;
         sv_ff    <= 1'b0;
         idx_ff   <= '0;
         final_ff <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         len_ff   <= len_in;
         tally_ff <= tally_in;
         run_ff   <= run_in;
         sv_ff    <= sv_in;
         idx_ff   <= idx_in;
         final_ff <= final_in;
         ok_ff    <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      qa_ff      <= qa_in;
      qb_ff      <= qb_in;
      amt_ff     <= amt_in;
      sidx_ff    <= sidx_in;
      sum_ff     <= sum_in;
      best_ff    <= best_in;
      out_max_ff <= out_max_in;
      out_cnt_ff <= out_cnt_in;
   end

   assign stat.query_final = final_ff;
   assign stat.sweep_done  = sv_ff && (sidx_ff == LAST_IDX);

   assign max_value     = out_max_ff;
   assign ignored_count = out_cnt_ff;

endmodule

FILE: sv/rapm_chk.sv
`timescale 1ns / 1ps

module rapm_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_final,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rapm_pkg::MAX_W-1:0]  rsp_max,
   input logic [rapm_pkg::CNT_W-1:0]  rsp_cnt
);

   // clearing pass holds off queries right after reset
   a_reset_blocks: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("query accepted during clearing pass");

   // two store updates follow every accepted query
   a_query_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready ##1 !req_ready)
      else $error("query accepted during store update");

   // a non-final query never produces a result beat
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_final) |=>
         !$rose(rsp_valid) ##1 !$rose(rsp_valid) ##1 !$rose(rsp_valid))
      else $error("result after non-final query");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         rsp_valid && $stable(rsp_max) && $stable(rsp_cnt))
      else $error("result beat changed while stalled");

endmodule

bind range_add_max_prefix_core rapm_chk u_rapm_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_final (req_chan.final_query),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_max   (rsp_chan.max_value),
   .rsp_cnt   (rsp_chan.ignored_count)
);
